>>> hdl/ghacc_pkg.sv
`default_nettype none

package ghacc_pkg;

  localparam int NUM_BINS     = 4096;
  localparam int NUM_FEATURES = 256;

  localparam int OP_W   = 2;
  localparam int BIN_W  = 12;
  localparam int FEAT_W = 8;
  localparam int OFF_W  = 12;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int GBIN_W = BIN_W + 1;

  localparam int BIN_ADDR_W  = $clog2(NUM_BINS);
  localparam int FEAT_ADDR_W = $clog2(NUM_FEATURES);

  // front-to-back queue, power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ACCUM  = 2'd0,
    OP_READ   = 2'd1,
    OP_OFFSET = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACC      = 2'd0,
    KIND_READ     = 2'd1,
    KIND_READ_OOR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BIN_W-1:0]   bin;
    logic [VAL_W-1:0]   grad;
    logic [VAL_W-1:0]   hess;
  } q_item_t;

  typedef struct packed {
    logic               sat;
    logic [SUM_W-1:0]   hsum;
    logic [SUM_W-1:0]   gsum;
  } hist_word_t;

endpackage

`default_nettype wire

>>> hdl/ghacc_front.sv
`default_nettype none

module ghacc_front import ghacc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [BIN_W-1:0]  in_bin_index,
  input  logic [FEAT_W-1:0] in_feature,
  input  logic [OFF_W-1:0]  in_offset_value,
  input  logic [VAL_W-1:0]  in_gradient,
  input  logic [VAL_W-1:0]  in_hessian,
  input  logic              dense_mode,
  input  logic              blocked,
  input  logic              q_full,
  output logic              push,
  output q_item_t           push_item
);

  logic [OFF_W-1:0]       off_mem [NUM_FEATURES];
  logic [OFF_W-1:0]       off_rd_r;
  logic                   clr_busy_r;
  logic [FEAT_ADDR_W-1:0] clr_cnt_r;

  logic                   f1_valid_r;
  logic                   f1_valid_nxt;
  op_t                    f1_op_r;
  logic [BIN_W-1:0]       f1_bin_r;
  logic                   f1_feat_ok_r;
  logic [VAL_W-1:0]       f1_grad_r;
  logic [VAL_W-1:0]       f1_hess_r;

  logic                   accept;
  logic                   feat_ok;
  logic                   off_we;
  logic [FEAT_ADDR_W-1:0] off_waddr;
  logic [OFF_W-1:0]       off_wdata;
  logic                   want;
  logic [GBIN_W-1:0]      gbin;

  assign feat_ok = 32'(in_feature) < NUM_FEATURES;
  assign accept  = in_valid && !in_stall;

  // offset table: swept to zero after reset, then written by offset items
  always_comb begin
    if (clr_busy_r) begin
      off_we    = 1'b1;
      off_waddr = clr_cnt_r;
      off_wdata = '0;
    end else begin
      off_we    = accept && (op_t'(in_operation) == OP_OFFSET) && feat_ok;
      off_waddr = in_feature[FEAT_ADDR_W-1:0];
      off_wdata = in_offset_value;
    end
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    if (accept) begin
      off_rd_r <= off_mem[in_feature[FEAT_ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == FEAT_ADDR_W'(NUM_FEATURES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // classify the held item
  always_comb begin
    gbin      = {1'b0, f1_bin_r} + (dense_mode ? {1'b0, off_rd_r} : '0);
    want      = 1'b0;
    push_item = '{kind: KIND_ACC, bin: gbin[BIN_W-1:0], grad: f1_grad_r, hess: f1_hess_r};
    case (f1_op_r)
      OP_ACCUM: begin
        want = (!dense_mode || f1_feat_ok_r) && (32'(gbin) < NUM_BINS);
      end
      OP_READ: begin
        want          = 1'b1;
        push_item.bin = f1_bin_r;
        push_item.kind = (32'(f1_bin_r) < NUM_BINS) ? KIND_READ : KIND_READ_OOR;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  assign push         = f1_valid_r && want && !q_full;
  assign in_stall     = clr_busy_r || blocked || (f1_valid_r && want && q_full);
  assign f1_valid_nxt = accept || (f1_valid_r && want && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r      <= op_t'(in_operation);
      f1_bin_r     <= in_bin_index;
      f1_feat_ok_r <= feat_ok;
      f1_grad_r    <= in_gradient;
      f1_hess_r    <= in_hessian;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ghacc_fifo.sv
`default_nettype none

module ghacc_fifo import ghacc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output q_item_t q_item
);

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign full    = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("queue count out of bounds");

endmodule

`default_nettype wire

>>> hdl/ghacc_back.sv
`default_nettype none

module ghacc_back import ghacc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  q_item_t          q_item,
  output logic             pop,
  output logic             clr_busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [BIN_W-1:0] out_bin,
  output logic [SUM_W-1:0] out_gradient_sum,
  output logic [SUM_W-1:0] out_hessian_sum,
  output logic             out_saturated
);

  hist_word_t            hist_mem [NUM_BINS];
  hist_word_t            rd_r;

  logic                  clr_busy_r;
  logic [BIN_ADDR_W-1:0] clr_cnt_r;

  logic                  b1_valid_r;
  q_item_t               b1_item_r;

  logic                  wb_valid_r;
  logic [BIN_ADDR_W-1:0] wb_addr_r;
  hist_word_t            wb_data_r;

  logic                  out_valid_r;
  logic [BIN_W-1:0]      out_bin_r;
  logic [SUM_W-1:0]      out_gsum_r;
  logic [SUM_W-1:0]      out_hsum_r;
  logic                  out_sat_r;

  logic                  out_can_load;
  logic                  b1_adv;
  logic                  b1_free;
  logic [BIN_ADDR_W-1:0] b1_addr;
  hist_word_t            cur;
  hist_word_t            upd;
  logic [SUM_W:0]        g_res;
  logic [SUM_W:0]        h_res;
  logic                  item_we;
  logic                  mem_we;
  logic [BIN_ADDR_W-1:0] mem_waddr;
  hist_word_t            mem_wdata;

  // {overflow, clamped sum}
  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] acc,
                                             input logic [VAL_W-1:0] add);
    logic [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - VAL_W){add[VAL_W-1]}}, add};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return {1'b1, (s[SUM_W] ? SUM_MIN : SUM_MAX)};
    end
    return {1'b0, s[SUM_W-1:0]};
  endfunction

  assign out_can_load = !out_valid_r || !out_stall;
  assign b1_adv  = b1_valid_r && ((b1_item_r.kind == KIND_ACC) || out_can_load);
  assign b1_free = !b1_valid_r || b1_adv;
  assign pop     = q_valid && !clr_busy_r && b1_free;
  assign b1_addr = b1_item_r.bin[BIN_ADDR_W-1:0];

  // bypass the write that landed on the same edge as this item's read
  assign cur = (wb_valid_r && (wb_addr_r == b1_addr)) ? wb_data_r : rd_r;

  always_comb begin
    g_res = sat_add(cur.gsum, b1_item_r.grad);
    h_res = sat_add(cur.hsum, b1_item_r.hess);
    upd   = '0;
    case (b1_item_r.kind)
      KIND_ACC: begin
        upd.gsum = g_res[SUM_W-1:0];
        upd.hsum = h_res[SUM_W-1:0];
        upd.sat  = cur.sat || g_res[SUM_W] || h_res[SUM_W];
      end
      default: begin
        upd = '0;  // read clears the bin
      end
    endcase
  end

  assign item_we = b1_adv && (b1_item_r.kind != KIND_READ_OOR);

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = item_we;
      mem_waddr = b1_addr;
      mem_wdata = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_r <= hist_mem[q_item.bin[BIN_ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == BIN_ADDR_W'(NUM_BINS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b1_free) begin
        b1_valid_r <= pop;
      end
      if (item_we) begin
        wb_valid_r <= 1'b1;
      end
      if (b1_adv && (b1_item_r.kind != KIND_ACC)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_item_r <= q_item;
    end
    if (item_we) begin
      wb_addr_r <= b1_addr;
      wb_data_r <= upd;
    end
    if (b1_adv && (b1_item_r.kind != KIND_ACC)) begin
      out_bin_r <= b1_item_r.bin;
      if (b1_item_r.kind == KIND_READ_OOR) begin
        out_gsum_r <= '0;
        out_hsum_r <= '0;
        out_sat_r  <= 1'b1;
      end else begin
        out_gsum_r <= cur.gsum;
        out_hsum_r <= cur.hsum;
        out_sat_r  <= cur.sat;
      end
    end
  end

  assign clr_busy         = clr_busy_r;
  assign out_valid        = out_valid_r;
  assign out_bin          = out_bin_r;
  assign out_gradient_sum = out_gsum_r;
  assign out_hessian_sum  = out_hsum_r;
  assign out_saturated    = out_sat_r;

  a_b1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b1_valid_r && !b1_adv |=> b1_valid_r && $stable(b1_item_r))
    else $error("stalled bin update lost its item");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !pop && !b1_valid_r) else $error("item taken during clear sweep");

endmodule

`default_nettype wire

>>> hdl/gradient_histogram_accumulator.sv
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  operation, bin_index, feature, offset_value,
//                                        gradient, hessian
// out      output     out_valid/out_stall bin, gradient_sum, hessian_sum, saturated
// cfg      input      cfg_valid/cfg_ready dense_mode
//
// Sustained rate is one item per cycle unless out_stall or the reset sweep holds it: the
// histogram memory takes one read and one write per cycle, with a one-entry write bypass
// so back-to-back hits on a bin chain. A read result passes the front register, queue,
// bin-update register and out register before it shows on out_*. After reset
// in_stall stays high while the histogram memory (and the shorter feature offset table)
// is swept to zero. A stalled out channel backs up via a four-entry queue to in_stall.

module gradient_histogram_accumulator import ghacc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [BIN_W-1:0]        in_bin_index,
  input  logic [FEAT_W-1:0]       in_feature,
  input  logic [OFF_W-1:0]        in_offset_value,
  input  logic signed [VAL_W-1:0] in_gradient,
  input  logic signed [VAL_W-1:0] in_hessian,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BIN_W-1:0]        out_bin,
  output logic signed [SUM_W-1:0] out_gradient_sum,
  output logic signed [SUM_W-1:0] out_hessian_sum,
  output logic                    out_saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_dense_mode
);

  logic             dense_mode_r;
  logic             q_full;
  logic             push;
  q_item_t          push_item;
  logic             pop;
  logic             q_valid;
  q_item_t          q_item;
  logic             back_clr_busy;
  logic [SUM_W-1:0] gsum;
  logic [SUM_W-1:0] hsum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dense_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dense_mode_r <= cfg_dense_mode;
    end
  end

  ghacc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_bin_index    (in_bin_index),
    .in_feature      (in_feature),
    .in_offset_value (in_offset_value),
    .in_gradient     ($unsigned(in_gradient)),
    .in_hessian      ($unsigned(in_hessian)),
    .dense_mode      (dense_mode_r),
    .blocked         (back_clr_busy),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  ghacc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  ghacc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .clr_busy         (back_clr_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bin          (out_bin),
    .out_gradient_sum (gsum),
    .out_hessian_sum  (hsum),
    .out_saturated    (out_saturated)
  );

  assign out_gradient_sum = $signed(gsum);
  assign out_hessian_sum  = $signed(hsum);

endmodule

`default_nettype wire
